### rtl/afhp_pkg.sv
package afhp_pkg;

  localparam int OffsetBitsDefault = 24;

  localparam logic [7:0] MpegSync0 = 8'hFF;
  localparam logic [7:0] MpegSync1 = 8'hF8;
  localparam logic [7:0] MpegMask  = 8'hF8;
  localparam logic [7:0] Ac3Sync0  = 8'h0B;
  localparam logic [7:0] Ac3Sync1  = 8'h77;
  localparam logic [7:0] Ac3Mask   = 8'hFF;
  localparam logic [2:0] MpegLen   = 3'd4;
  localparam logic [2:0] Ac3Len    = 3'd6;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_SYNC    = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_LAYER   = 3'd1;
  localparam logic [2:0] ST_BAD_BITRATE = 3'd2;
  localparam logic [2:0] ST_BAD_RATE    = 3'd3;
  localparam logic [2:0] ST_FREE_FORMAT = 3'd4;
  localparam logic [2:0] ST_BAD_BSID    = 3'd5;

  localparam logic [2:0] SZ_Q         = 3'd0;
  localparam logic [2:0] SZ_Q_X4      = 3'd1;
  localparam logic [2:0] SZ_WORDS_X2  = 3'd2;
  localparam logic [2:0] SZ_KBPS_X4   = 3'd3;
  localparam logic [2:0] SZ_KBPS_X6   = 3'd4;

  localparam int DivWidth      = 28;
  localparam int DivisorWidth  = 18;
  localparam int MulWidth      = 19;
  localparam int DivCountWidth = 5;
  localparam logic [DivCountWidth-1:0] DivLast = DivCountWidth'(DivWidth - 1);

  localparam logic [MulWidth-1:0] MulLayer1  = 19'd12000;
  localparam logic [MulWidth-1:0] MulLayer23 = 19'd144000;

  localparam logic [4:0] Ac3BsidLimit = 5'd12;
  localparam logic [23:0] SyncOutMax = 24'hFFFFFF;

  localparam logic [9:0] MpegKbps [3][16] = '{
    '{10'd0, 10'd32, 10'd64, 10'd96, 10'd128, 10'd160, 10'd192, 10'd224,
      10'd256, 10'd288, 10'd320, 10'd352, 10'd384, 10'd416, 10'd448, 10'd0},
    '{10'd0, 10'd32, 10'd48, 10'd56, 10'd64, 10'd80, 10'd96, 10'd112,
      10'd128, 10'd160, 10'd192, 10'd224, 10'd256, 10'd320, 10'd384, 10'd0},
    '{10'd0, 10'd32, 10'd40, 10'd48, 10'd56, 10'd64, 10'd80, 10'd96,
      10'd112, 10'd128, 10'd160, 10'd192, 10'd224, 10'd256, 10'd320, 10'd0}
  };

  localparam logic [15:0] MpegRate [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
  localparam logic [15:0] Ac3Rate  [4] = '{16'd48000, 16'd44100, 16'd32000, 16'd0};

  localparam logic [9:0] Ac3Kbps [32] = '{
    10'd32, 10'd40, 10'd48, 10'd56, 10'd64, 10'd80, 10'd96, 10'd112,
    10'd128, 10'd160, 10'd192, 10'd224, 10'd256, 10'd320, 10'd384, 10'd448,
    10'd512, 10'd576, 10'd640, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0
  };

  // 44.1 kHz words per frame, kbps * 320 / 147 rounded down
  localparam logic [10:0] Ac3Words44k [32] = '{
    11'd69, 11'd87, 11'd104, 11'd121, 11'd139, 11'd174, 11'd208, 11'd243,
    11'd278, 11'd348, 11'd417, 11'd487, 11'd557, 11'd696, 11'd835, 11'd975,
    11'd1114, 11'd1253, 11'd1393, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0,
    11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       window_start;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  layer;
    logic [9:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding;
    logic [11:0] frame_bytes;
    logic [23:0] sync_offset;
  } result_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic mul;
    logic div_step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic header_done;
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [15:0] ac3_rate(input logic [1:0] fscod, input logic [4:0] bsid);
    logic [15:0] base;
    base = Ac3Rate[fscod];
    unique case (bsid)
      5'd9:    return base >> 1;
      5'd10:   return base >> 2;
      5'd11:   return base >> 3;
      default: return base;
    endcase
  endfunction

endpackage

### rtl/afhp_ctrl.sv
module afhp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  afhp_pkg::dp_status_t stat,
  output afhp_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_stall   = (state != S_IDLE);
  assign cmd.accept   = (state == S_IDLE) && item_valid;
  assign cmd.decode   = (state == S_DECODE);
  assign cmd.mul      = (state == S_MUL);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.load     = (state == S_FINISH) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid && stat.header_done) state_next = S_DECODE;
      end
      S_DECODE: state_next = S_MUL;
      S_MUL: begin
        state_next = stat.need_div ? S_DIV : S_FINISH;
      end
      S_DIV: begin
        if (stat.div_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/afhp_dp.sv
module afhp_dp #(
  parameter int OFFSET_BITS = afhp_pkg::OffsetBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  afhp_pkg::item_t      item,
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  input  afhp_pkg::dp_cmd_t    cmd,
  output afhp_pkg::dp_status_t stat,
  input  logic                 result_stall,
  output logic                 result_valid,
  output afhp_pkg::result_t    result
);

  localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};
  localparam int DW = afhp_pkg::DivWidth;
  localparam int RW = afhp_pkg::DivisorWidth;

  logic                   stream_type;
  logic [1:0]             hunt_phase;
  logic [7:0]             header_bytes [1:5];
  logic [2:0]             bytes_collected;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] sync_position;

  logic [7:0]             first_byte;
  logic [7:0]             second_byte;
  logic [7:0]             sync_mask;
  logic [2:0]             header_len;
  logic [1:0]             phase_eff;
  logic [2:0]             count_eff;
  logic [2:0]             count_inc;
  logic [OFFSET_BITS-1:0] pos_eff;

  // decoded header
  logic [2:0]                          dec_status;
  logic [1:0]                          dec_layer;
  logic [9:0]                          dec_kbps;
  logic [15:0]                         dec_rate;
  logic                                dec_pad;
  logic                                dec_addend;
  logic [2:0]                          dec_size_sel;
  logic [afhp_pkg::MulWidth-1:0]       dec_mul;
  logic [RW-1:0]                       dec_divisor;
  logic [10:0]                         dec_words;

  logic [2:0]                          hd_status;
  logic [1:0]                          hd_layer;
  logic [9:0]                          hd_kbps;
  logic [15:0]                         hd_rate;
  logic                                hd_pad;
  logic                                hd_addend;
  logic [2:0]                          hd_size_sel;
  logic [afhp_pkg::MulWidth-1:0]       hd_mul;
  logic [RW-1:0]                       hd_divisor;
  logic [10:0]                         hd_words;

  logic [1:0] m_code;
  logic [1:0] m_ridx;
  logic [3:0] m_bidx;
  logic [1:0] m_layer;
  logic [1:0] m_row;
  logic [5:0] a_code;
  logic [1:0] a_fscod;
  logic [4:0] a_bsid;
  logic [9:0] a_kbps;

  // shared divider
  logic [DW-1:0]                       div_work;
  logic [RW-1:0]                       rem;
  logic [RW:0]                         rem_shift;
  logic                                rem_ge;
  logic [afhp_pkg::DivCountWidth-1:0]  div_count;

  logic [11:0]        q_base;
  logic [12:0]        q_sum;
  logic [12:0]        size_wide;
  logic [32:0]        sync_wide;
  afhp_pkg::result_t  result_next;

  assign first_byte  = stream_type ? afhp_pkg::Ac3Sync0 : afhp_pkg::MpegSync0;
  assign second_byte = stream_type ? afhp_pkg::Ac3Sync1 : afhp_pkg::MpegSync1;
  assign sync_mask   = stream_type ? afhp_pkg::Ac3Mask  : afhp_pkg::MpegMask;
  assign header_len  = stream_type ? afhp_pkg::Ac3Len   : afhp_pkg::MpegLen;

  assign phase_eff = item.window_start ? afhp_pkg::PH_HUNT : hunt_phase;
  assign count_eff = item.window_start ? 3'd0 : bytes_collected;
  assign pos_eff   = item.window_start ? '0 : byte_position;
  assign count_inc = count_eff + 3'd1;

  assign stat.header_done = (phase_eff == afhp_pkg::PH_COLLECT) && (count_inc >= header_len);
  assign stat.need_div    = (dec_status == afhp_pkg::ST_OK) &&
                            ((dec_size_sel == afhp_pkg::SZ_Q) ||
                             (dec_size_sel == afhp_pkg::SZ_Q_X4));
  assign stat.div_last    = (div_count == afhp_pkg::DivLast);
  assign stat.out_free    = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_type     <= 1'b0;
      hunt_phase      <= afhp_pkg::PH_HUNT;
      bytes_collected <= 3'd0;
      byte_position   <= '0;
      sync_position   <= '0;
    end else if (cfg_write) begin
      stream_type     <= cfg_data;
      hunt_phase      <= afhp_pkg::PH_HUNT;
      bytes_collected <= 3'd0;
    end else if (cmd.accept) begin
      byte_position   <= (pos_eff == PosMax) ? pos_eff : pos_eff + 1'b1;
      hunt_phase      <= phase_eff;
      bytes_collected <= count_eff;
      unique case (phase_eff)
        afhp_pkg::PH_HUNT: begin
          if (item.data_byte == first_byte) begin
            hunt_phase    <= afhp_pkg::PH_SYNC;
            sync_position <= pos_eff;
          end
        end
        afhp_pkg::PH_SYNC: begin
          if ((item.data_byte & sync_mask) == second_byte) begin
            bytes_collected <= 3'd2;
            hunt_phase      <= afhp_pkg::PH_COLLECT;
          end else if (item.data_byte == first_byte) begin
            sync_position <= pos_eff;
          end else begin
            hunt_phase <= afhp_pkg::PH_HUNT;
          end
        end
        default: begin
          if (count_inc >= header_len) begin
            hunt_phase      <= afhp_pkg::PH_HUNT;
            bytes_collected <= 3'd0;
          end else begin
            bytes_collected <= count_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !cfg_write) begin
      for (int i = 1; i <= 5; i++) begin
        if (phase_eff == afhp_pkg::PH_SYNC && i == 1 &&
            (item.data_byte & sync_mask) == second_byte) begin
          header_bytes[i] <= item.data_byte;
        end
        if (phase_eff == afhp_pkg::PH_COLLECT && count_eff == 3'(i)) begin
          header_bytes[i] <= item.data_byte;
        end
      end
    end
  end

  // header decode
  assign m_code  = header_bytes[1][2:1];
  assign m_ridx  = header_bytes[2][3:2];
  assign m_bidx  = header_bytes[2][7:4];
  assign m_layer = 2'(3'd4 - {1'b0, m_code});
  assign m_row   = m_layer - 2'd1;
  assign a_code  = header_bytes[4][5:0];
  assign a_fscod = header_bytes[4][7:6];
  assign a_bsid  = header_bytes[5][7:3];
  assign a_kbps  = afhp_pkg::Ac3Kbps[a_code[5:1]];

  always_comb begin
    hd_status   = afhp_pkg::ST_OK;
    hd_layer    = 2'd0;
    hd_kbps     = 10'd0;
    hd_rate     = 16'd0;
    hd_pad      = 1'b0;
    hd_addend   = 1'b0;
    hd_size_sel = afhp_pkg::SZ_Q;
    hd_mul      = '0;
    hd_divisor  = '0;
    hd_words    = 11'd0;
    if (!stream_type) begin
      if (m_code == 2'd0) begin
        hd_status = afhp_pkg::ST_BAD_LAYER;
      end else if (m_ridx == 2'd3) begin
        hd_status = afhp_pkg::ST_BAD_RATE;
      end else if (m_bidx == 4'd15) begin
        hd_status = afhp_pkg::ST_BAD_BITRATE;
      end else if (m_bidx == 4'd0) begin
        hd_status = afhp_pkg::ST_FREE_FORMAT;
      end else begin
        hd_layer    = m_layer;
        hd_kbps     = afhp_pkg::MpegKbps[m_row][m_bidx];
        hd_rate     = afhp_pkg::MpegRate[m_ridx];
        hd_pad      = header_bytes[2][1];
        hd_addend   = header_bytes[2][1];
        hd_size_sel = (m_layer == 2'd1) ? afhp_pkg::SZ_Q_X4 : afhp_pkg::SZ_Q;
        hd_mul      = (m_layer == 2'd1) ? afhp_pkg::MulLayer1 : afhp_pkg::MulLayer23;
        hd_divisor  = RW'(afhp_pkg::MpegRate[m_ridx]);
      end
    end else begin
      if (a_bsid >= afhp_pkg::Ac3BsidLimit) begin
        hd_status = afhp_pkg::ST_BAD_BSID;
      end else if (a_fscod == 2'd3) begin
        hd_status = afhp_pkg::ST_BAD_RATE;
      end else if (a_kbps == 10'd0) begin
        hd_status = afhp_pkg::ST_BAD_BITRATE;
      end else begin
        hd_kbps   = a_kbps;
        hd_rate   = afhp_pkg::ac3_rate(a_fscod, a_bsid);
        hd_addend = a_code[0];
        hd_words  = afhp_pkg::Ac3Words44k[a_code[5:1]];
        case (a_fscod)
          2'd0:    hd_size_sel = afhp_pkg::SZ_KBPS_X4;
          2'd1:    hd_size_sel = afhp_pkg::SZ_WORDS_X2;
          default: hd_size_sel = afhp_pkg::SZ_KBPS_X6;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      dec_status   <= hd_status;
      dec_layer    <= hd_layer;
      dec_kbps     <= hd_kbps;
      dec_rate     <= hd_rate;
      dec_pad      <= hd_pad;
      dec_addend   <= hd_addend;
      dec_size_sel <= hd_size_sel;
      dec_mul      <= hd_mul;
      dec_divisor  <= hd_divisor;
      dec_words    <= hd_words;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_shift = {rem, div_work[DW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dec_divisor});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      div_work  <= DW'(dec_kbps * dec_mul);
      rem       <= '0;
      div_count <= '0;
    end else if (cmd.div_step) begin
      rem       <= rem_ge ? RW'(rem_shift - {1'b0, dec_divisor}) : RW'(rem_shift);
      div_work  <= {div_work[DW-2:0], rem_ge};
      div_count <= div_count + 1'b1;
    end
  end

  assign q_base    = (dec_size_sel == afhp_pkg::SZ_WORDS_X2) ? {1'b0, dec_words} :
                                                               div_work[11:0];
  assign q_sum     = {1'b0, q_base} + {12'd0, dec_addend};
  assign sync_wide = 33'(sync_position);

  always_comb begin
    case (dec_size_sel)
      afhp_pkg::SZ_Q:        size_wide = q_sum;
      afhp_pkg::SZ_Q_X4:     size_wide = q_sum << 2;
      afhp_pkg::SZ_WORDS_X2: size_wide = q_sum << 1;
      afhp_pkg::SZ_KBPS_X4:  size_wide = {1'b0, dec_kbps, 2'b00};
      default:               size_wide = {1'b0, dec_kbps, 2'b00} + {2'b00, dec_kbps, 1'b0};
    endcase
    result_next.status         = dec_status;
    result_next.layer          = dec_layer;
    result_next.bitrate_kbps   = dec_kbps;
    result_next.sample_rate_hz = dec_rate;
    result_next.padding        = dec_pad;
    result_next.frame_bytes    = (dec_status == afhp_pkg::ST_OK) ? size_wide[11:0] : 12'd0;
    result_next.sync_offset    = (sync_wide > 33'(afhp_pkg::SyncOutMax)) ?
                                 afhp_pkg::SyncOutMax : sync_wide[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result <= result_next;
    end
  end

endmodule

### rtl/audio_frame_header_parser.sv
// audio frame header parser: hunts for an MPEG audio or AC3 sync word in a byte stream
// input channel item_valid/item_stall/item carries one stream byte and a window start flag
// per transaction; output channel result_valid/result_stall/result carries one decoded
// header per transaction; cfg_valid/cfg_ready/cfg_data writes stream_type (0 MPEG, 1 AC3)
// a new byte is taken every cycle while no header is being decoded (item_stall low)
// the byte that finishes a header starts the decoder: decode, multiply, then the
// bit-serial frame-size divider (skipped when no divide is needed) and a load state;
// item_stall is high for that time
// the result shows on result_valid the cycle after the load cycle and is held while
// result_stall is high; bytes keep flowing in meanwhile, only the next finished header
// waits in the load cycle until the output register is free
// cfg_ready is always high; a stream_type write restarts the hunt
// reset clears the hunt, byte position, stream_type and result_valid; a stalled result is not overwritten
module audio_frame_header_parser #(
  parameter int OFFSET_BITS = afhp_pkg::OffsetBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  afhp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output afhp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  afhp_pkg::dp_cmd_t    cmd;
  afhp_pkg::dp_status_t dstat;

  assign cfg_ready = 1'b1;

  afhp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (dstat),
    .cmd        (cmd)
  );

  afhp_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (dstat),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  a_done_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && dstat.header_done |=> item_stall)
    else $error("header completion did not stall input");

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == afhp_pkg::ST_OK |-> result.frame_bytes != 12'd0)
    else $error("ok result with zero frame size");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != afhp_pkg::ST_OK |->
      result.frame_bytes == 12'd0 && result.bitrate_kbps == 10'd0 && result.layer == 2'd0)
    else $error("error result carries decoded fields");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !result_valid || !result_stall)
    else $error("result overwritten while stalled");

endmodule
